FILE: rtl/core/ura_pkg.sv
// Shared types and constants of the uniform register ALU.
package ura_pkg;

  // Index value that names no register: reads as zero, writes are dropped.
  localparam logic [7:0] NO_REG = 8'd255;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SHAMT_W = 5;

  typedef enum logic [2:0] {
    OP_MOVE32 = 3'd0,
    OP_MOVE64 = 3'd1,
    OP_ADD3   = 3'd2,
    OP_SHL    = 3'd3,
    OP_SHR    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    BK_REG   = 2'd0,
    BK_IMM   = 2'd1,
    BK_OTHER = 2'd2
  } b_kind_e;

  // One decoded instruction.
  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         dest_index;
    logic               a_is_register;
    logic [7:0]         a_index;
    logic               a_negate;
    logic [1:0]         b_kind;
    logic signed [63:0] b_value;
    logic               b_negate;
    logic               c_is_register;
    logic [7:0]         c_index;
    logic               c_negate;
  } ura_req_t;

  // The register write reported for one instruction.
  typedef struct packed {
    logic              wrote;
    logic [7:0]        write_index;
    logic [WORD_W-1:0] write_value;
    logic              wrote_pair;
    logic [WORD_W-1:0] pair_value;
  } ura_res_t;

endpackage

FILE: rtl/core/ura_if.sv
// Valid/ready channel interfaces for instruction requests and write results.
interface ura_req_if;
  logic              valid;
  logic              ready;
  ura_pkg::ura_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ura_res_if;
  logic              valid;
  logic              ready;
  ura_pkg::ura_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/uniform_register_alu.sv
// Uniform register file with a three-input adder, shifter and immediate moves.
//
//   channel | direction | payload    | meaning
//   --------+-----------+------------+------------------------------------------
//   req_i   | in        | ura_req_t  | one decoded instruction per request
//   res_o   | out       | ura_res_t  | the register write(s) the instruction made
//
// A request is taken every cycle when the result side keeps up; it is held in
// the operand read stage, then its result in the result register. The operand
// read stage holds a request while the result register waits on res_o.ready,
// and req_i.ready falls only then. Reset clears the per-register valid bits
// at once, so every register reads as zero right after reset and no clearing
// pass is needed.
module uniform_register_alu #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ura_req_if.sink          req_i,
  ura_res_if.source        res_o
);
  import ura_pkg::*;

  // The file is split into an even and an odd bank so that a 64-bit move can
  // write its two neighboring registers in the same cycle. Each bank is kept
  // twice: one copy serves the a and b reads, the other serves the c read.
  localparam int unsigned IW  = $clog2(NUM_REGS);
  localparam int unsigned BD  = (NUM_REGS + 1) / 2;
  localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam logic [8:0]  NUM_REGS_W = 9'(NUM_REGS);

  logic [WORD_W-1:0] mem_even_ab_q [BD];
  logic [WORD_W-1:0] mem_even_c_q  [BD];
  logic [WORD_W-1:0] mem_odd_ab_q  [BD];
  logic [WORD_W-1:0] mem_odd_c_q   [BD];

  // One valid bit per register; an entry never written reads as zero.
  logic [NUM_REGS-1:0] vld_q;

  // Operand read stage.
  logic              s1_vld_q;
  ura_req_t          s1_req_q;
  logic [WORD_W-1:0] a_even_q, a_odd_q, b_even_q, b_odd_q, c_even_q, c_odd_q;
  logic              a_ok_q, b_ok_q, c_ok_q;

  // The write made at the edge where the staged request read its operands;
  // the memories return the old word for it, so it is forwarded.
  logic              fw_w_q, fw_p_q;
  logic [7:0]        fw_idx_q, fw_pidx_q;
  logic [WORD_W-1:0] fw_val_q, fw_pval_q;

  // Result register.
  logic     res_vld_q;
  ura_res_t res_q;

  logic accept, adv;
  logic a_in, b_in, c_in;
  logic [BAW-1:0] a_addr, b_addr, c_addr;

  assign adv           = s1_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready   = !s1_vld_q || adv;
  assign accept        = req_i.valid && req_i.ready;
  assign res_o.valid   = res_vld_q;
  assign res_o.data    = res_q;

  // Source indexes in range; the b index is a full 64-bit value.
  assign a_in = (req_i.data.a_index != NO_REG) && ({1'b0, req_i.data.a_index} < NUM_REGS_W);
  assign c_in = (req_i.data.c_index != NO_REG) && ({1'b0, req_i.data.c_index} < NUM_REGS_W);
  assign b_in = $unsigned(req_i.data.b_value) < 64'(NUM_REGS);

  assign a_addr = BAW'(req_i.data.a_index >> 1);
  assign b_addr = BAW'(req_i.data.b_value[7:0] >> 1);
  assign c_addr = BAW'(req_i.data.c_index >> 1);

  // Operand reads, captured with the request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i.data;
      a_even_q <= mem_even_ab_q[a_addr];
      a_odd_q  <= mem_odd_ab_q[a_addr];
      b_even_q <= mem_even_ab_q[b_addr];
      b_odd_q  <= mem_odd_ab_q[b_addr];
      c_even_q <= mem_even_c_q[c_addr];
      c_odd_q  <= mem_odd_c_q[c_addr];
      a_ok_q   <= a_in && vld_q[req_i.data.a_index[IW-1:0]];
      b_ok_q   <= b_in && vld_q[req_i.data.b_value[IW-1:0]];
      c_ok_q   <= c_in && vld_q[req_i.data.c_index[IW-1:0]];
    end
  end

  // Resolve one source: forwarded write, then stored word, then zero.
  function automatic logic [WORD_W-1:0] pick_src(
    input logic              hit_w,
    input logic              hit_p,
    input logic [WORD_W-1:0] val_w,
    input logic [WORD_W-1:0] val_p,
    input logic              ok,
    input logic [WORD_W-1:0] stored
  );
    logic [WORD_W-1:0] r;
    if (hit_w) begin
      r = val_w;
    end else if (hit_p) begin
      r = val_p;
    end else if (ok) begin
      r = stored;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  logic [WORD_W-1:0] a_rd, b_rd, c_rd;
  logic [WORD_W-1:0] a_add, b_add, c_add, imm_lo;
  logic [SHAMT_W-1:0] shamt;
  logic              dest_ok, pair_ok;
  logic              w_en, p_en;
  logic [7:0]        pidx;
  logic [WORD_W-1:0] w_val, p_val;

  always_comb begin
    a_rd = pick_src(fw_w_q && (s1_req_q.a_index == fw_idx_q),
                    fw_p_q && (s1_req_q.a_index == fw_pidx_q),
                    fw_val_q, fw_pval_q, a_ok_q,
                    s1_req_q.a_index[0] ? a_odd_q : a_even_q);
    b_rd = pick_src(fw_w_q && ($unsigned(s1_req_q.b_value) == {56'd0, fw_idx_q}),
                    fw_p_q && ($unsigned(s1_req_q.b_value) == {56'd0, fw_pidx_q}),
                    fw_val_q, fw_pval_q, b_ok_q,
                    s1_req_q.b_value[0] ? b_odd_q : b_even_q);
    c_rd = pick_src(fw_w_q && (s1_req_q.c_index == fw_idx_q),
                    fw_p_q && (s1_req_q.c_index == fw_pidx_q),
                    fw_val_q, fw_pval_q, c_ok_q,
                    s1_req_q.c_index[0] ? c_odd_q : c_even_q);

    imm_lo = s1_req_q.b_value[WORD_W-1:0];

    a_add = '0;
    if (s1_req_q.a_is_register) begin
      a_add = s1_req_q.a_negate ? (~a_rd + 32'd1) : a_rd;
    end
    b_add = (b_kind_e'(s1_req_q.b_kind) == BK_REG) ? b_rd : '0;
    // The immediate stands in for the third addend when no c register is given.
    if (s1_req_q.c_is_register && (s1_req_q.c_index != NO_REG)) begin
      c_add = s1_req_q.c_negate ? (~c_rd + 32'd1) : c_rd;
    end else if (b_kind_e'(s1_req_q.b_kind) == BK_IMM) begin
      c_add = s1_req_q.b_negate ? (~imm_lo + 32'd1) : imm_lo;
    end else begin
      c_add = '0;
    end

    shamt = (b_kind_e'(s1_req_q.b_kind) == BK_IMM) ? s1_req_q.b_value[SHAMT_W-1:0] : '0;

    dest_ok = (s1_req_q.dest_index != NO_REG) && ({1'b0, s1_req_q.dest_index} < NUM_REGS_W);
    pair_ok = ({1'b0, s1_req_q.dest_index} + 9'd1) < NUM_REGS_W;
    pidx    = s1_req_q.dest_index + 8'd1;

    w_en  = 1'b0;
    p_en  = 1'b0;
    w_val = '0;
    p_val = '0;
    if (dest_ok) begin
      case (op_e'(s1_req_q.operation))
        OP_MOVE32: begin
          w_en  = 1'b1;
          w_val = imm_lo;
        end
        OP_MOVE64: begin
          w_en  = 1'b1;
          w_val = imm_lo;
          p_en  = pair_ok;
          p_val = pair_ok ? s1_req_q.b_value[63:WORD_W] : '0;
        end
        OP_ADD3: begin
          w_en  = 1'b1;
          w_val = a_add + b_add + c_add;
        end
        OP_SHL: begin
          w_en  = s1_req_q.a_is_register;
          w_val = s1_req_q.a_is_register ? (a_rd << shamt) : '0;
        end
        OP_SHR: begin
          w_en  = s1_req_q.a_is_register;
          w_val = s1_req_q.a_is_register ? (a_rd >> shamt) : '0;
        end
        default: begin
          w_en = 1'b0;
        end
      endcase
    end
  end

  // Bank writes: the primary and the pair register always fall in different banks.
  logic              even_we, odd_we;
  logic [BAW-1:0]    even_addr, odd_addr;
  logic [WORD_W-1:0] even_val, odd_val;
  logic [NUM_REGS-1:0] vld_set;

  always_comb begin
    even_we   = adv && ((w_en && !s1_req_q.dest_index[0]) || (p_en && s1_req_q.dest_index[0]));
    odd_we    = adv && ((w_en && s1_req_q.dest_index[0]) || (p_en && !s1_req_q.dest_index[0]));
    even_addr = s1_req_q.dest_index[0] ? BAW'(pidx >> 1) : BAW'(s1_req_q.dest_index >> 1);
    odd_addr  = s1_req_q.dest_index[0] ? BAW'(s1_req_q.dest_index >> 1) : BAW'(pidx >> 1);
    even_val  = s1_req_q.dest_index[0] ? p_val : w_val;
    odd_val   = s1_req_q.dest_index[0] ? w_val : p_val;
    // Valid bits that this instruction's writes turn on.
    vld_set = '0;
    if (w_en) begin
      vld_set[s1_req_q.dest_index[IW-1:0]] = 1'b1;
    end
    if (p_en) begin
      vld_set[pidx[IW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (even_we) begin
      mem_even_ab_q[even_addr] <= even_val;
      mem_even_c_q[even_addr]  <= even_val;
    end
    if (odd_we) begin
      mem_odd_ab_q[odd_addr] <= odd_val;
      mem_odd_c_q[odd_addr]  <= odd_val;
    end
  end

  // Forwarded write record and result payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fw_idx_q             <= s1_req_q.dest_index;
      fw_pidx_q            <= pidx;
      fw_val_q             <= w_val;
      fw_pval_q            <= p_val;
      res_q.wrote          <= w_en;
      res_q.write_index    <= w_en ? s1_req_q.dest_index : 8'd0;
      res_q.write_value    <= w_val;
      res_q.wrote_pair     <= p_en;
      res_q.pair_value     <= p_val;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      fw_w_q    <= 1'b0;
      fw_p_q    <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
        fw_w_q    <= w_en;
        fw_p_q    <= p_en;
        vld_q     <= vld_q | vld_set;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

endmodule
